FILE: rtl/core/bba_pkg.sv
// Package: shared constants, controller states, datapath commands and status.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int MAX_ORDER_DEF    = 16;
  localparam int MIN_ORDER_DEF    = 5;
  localparam int HEADER_BYTES_DEF = 32;
  localparam logic [4:0] MERGE_FLOOR_RST = 5'd10;
  localparam int REQ_W   = 17;
  localparam int SIZE_W  = 18;
  localparam int ADDR_W  = 32;

  localparam logic CFG_REGION_BASE = 1'b0;
  localparam logic CFG_MERGE_FLOOR = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SRCH, S_POP_RD, S_POP_WR, S_SPLIT_A, S_SPLIT_B, S_AFIN,
    S_FRD, S_FCHK, S_MRD, S_MEVAL, S_PUSH_A, S_PUSH_B, S_FAIL, S_POST
  } state_t;

  typedef enum logic [4:0] {
    C_NOP, C_CLR, C_LOAD, C_STEP, C_POP_RD, C_POP_WR, C_SPLIT_A, C_SPLIT_B,
    C_AFIN, C_FRD, C_FCHK, C_MRD, C_MEVAL, C_PUSH_A, C_PUSH_B, C_FAIL, C_EMIT
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fit;
    logic head_nn;
    logic k_max;
    logic can_split;
    logic addr_bad;
    logic chk_bad;
    logic merge_en;
    logic k_lt_max;
    logic bud_match;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/bba_if.sv
// Interfaces: request channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface bba_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [16:0] request_bytes;
  logic [31:0] freed_address;
  modport source (output valid, operation, request_bytes, freed_address, input ready);
  modport sink (input valid, operation, request_bytes, freed_address, output ready);
endinterface

interface bba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] granted_address;
  logic        ok;
  modport source (output valid, granted_address, ok, input ready);
  modport sink (input valid, granted_address, ok, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bba_datapath.sv
// Datapath: block tables, free list heads, config registers, result registers.
`timescale 1ns / 1ps
`default_nettype none
module bba_datapath
  import bba_pkg::*;
#(
  parameter int MAX_ORDER    = MAX_ORDER_DEF,
  parameter int MIN_ORDER    = MIN_ORDER_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic [REQ_W-1:0]  req_bytes,
  input  wire logic [ADDR_W-1:0] freed_addr,
  output logic [ADDR_W-1:0]      granted_addr,
  output logic                   grant_ok
);

  localparam int IW   = MAX_ORDER - MIN_ORDER;
  localparam int NW   = IW + 1;
  localparam int NBLK = 1 << IW;
  localparam int NORD = MAX_ORDER - MIN_ORDER + 1;
  localparam int HW   = $clog2(NORD);
  localparam logic [NW-1:0] NULL_IDX = NW'(NBLK);
  localparam logic [4:0] MIN5 = 5'(MIN_ORDER);
  localparam logic [4:0] MAX5 = 5'(MAX_ORDER);

  logic [NW-1:0] heads_r [NORD];
  logic [NW-1:0] clr_r;
  logic [31:0]   base_r;
  logic [4:0]    floor_r;

  logic [4:0]        k_r;
  logic [SIZE_W-1:0] size_r;
  logic [31:0]       off_r;
  logic [IW-1:0]     h_r, up_r, bud_r;
  logic [NW-1:0]     oh_r;
  logic [31:0]       res_addr_r, out_addr_r;
  logic              res_ok_r, out_ok_r;

  logic          free_mem  [NBLK];
  logic [4:0]    order_mem [NBLK];
  logic [NW-1:0] next_mem  [NBLK];
  logic [IW-1:0] prev_mem  [NBLK];
  logic          rd_free_r;
  logic [4:0]    rd_order_r;
  logic [NW-1:0] rd_next_r;
  logic [IW-1:0] rd_prev_r;

  logic [4:0]    hk;
  logic [HW-1:0] hsel;
  logic [NW-1:0] head_q;
  logic [31:0]   size32, pow_k, pow_km1, omask;
  logic [IW-1:0] kbit, split_up, bud_idx, rd_addr, mg_idx;
  logic          bud_is_head;

  logic          fr_we, fr_wd, or_we, nx_we, pv_we;
  logic [IW-1:0] fr_wa, or_wa, nx_wa, pv_wa, pv_wd;
  logic [4:0]    or_wd;
  logic [NW-1:0] nx_wd;

  always_comb begin
    hk       = (cmd == C_SPLIT_A) ? k_r - 5'd1 : k_r;
    hsel     = HW'(hk - MIN5);
    head_q   = heads_r[hsel];
    size32   = 32'(size_r);
    pow_k    = 32'd1 << k_r;
    pow_km1  = 32'd1 << (k_r - 5'd1);
    omask    = (32'd1 << rd_order_r) - 32'd1;
    kbit     = IW'(1) << (k_r - MIN5);
    split_up = h_r + (IW'(1) << (k_r - 5'd1 - MIN5));
    bud_idx  = h_r ^ kbit;
    mg_idx   = ((h_r & kbit) != '0) ? bud_r : h_r;
    bud_is_head = (head_q == {1'b0, bud_r});
  end

  always_comb begin
    sts.clr_last  = (clr_r == NW'(NBLK - 1));
    sts.fit       = (size32 <= pow_k);
    sts.head_nn   = (head_q != NULL_IDX);
    sts.k_max     = (k_r == MAX5);
    sts.can_split = (k_r > MIN5) && (size32 <= pow_km1);
    sts.addr_bad  = ((off_r >> MAX_ORDER) != 32'd0) || (off_r[MIN_ORDER-1:0] != '0);
    sts.chk_bad   = (rd_order_r < MIN5) || (rd_order_r > MAX5) ||
                    ((off_r & omask) != 32'd0) || rd_free_r;
    sts.merge_en  = (rd_order_r < MAX5) && (rd_order_r > floor_r);
    sts.k_lt_max  = (k_r < MAX5);
    sts.bud_match = rd_free_r && (rd_order_r == k_r);
  end

  // Table write and read port selection per command.
  always_comb begin
    fr_we = 1'b0; fr_wa = h_r; fr_wd = 1'b0;
    or_we = 1'b0; or_wa = h_r; or_wd = k_r;
    nx_we = 1'b0; nx_wa = h_r; nx_wd = head_q;
    pv_we = 1'b0; pv_wa = h_r; pv_wd = '0;
    rd_addr = h_r;
    case (cmd)
      C_CLR: begin
        fr_we = 1'b1; or_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
        fr_wa = clr_r[IW-1:0]; or_wa = clr_r[IW-1:0];
        nx_wa = clr_r[IW-1:0]; pv_wa = clr_r[IW-1:0];
        fr_wd = (clr_r == '0);
        or_wd = (clr_r == '0) ? MAX5 : 5'd0;
        nx_wd = (clr_r == '0) ? NULL_IDX : '0;
      end
      C_POP_RD: rd_addr = head_q[IW-1:0];
      C_SPLIT_A: begin
        fr_we = 1'b1; or_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
        fr_wa = split_up; or_wa = split_up; nx_wa = split_up; pv_wa = split_up;
        fr_wd = 1'b1; or_wd = k_r - 5'd1;
      end
      C_SPLIT_B: begin
        pv_we = (oh_r != NULL_IDX);
        pv_wa = oh_r[IW-1:0];
        pv_wd = up_r;
      end
      C_AFIN: begin
        fr_we = 1'b1; or_we = 1'b1;
      end
      C_FRD: rd_addr = off_r[MIN_ORDER +: IW];
      C_MRD: rd_addr = bud_idx;
      C_MEVAL: begin
        // unlink the buddy, then stamp the merged block's new order
        nx_we = !bud_is_head;
        nx_wa = rd_prev_r;
        nx_wd = rd_next_r;
        pv_we = (rd_next_r != NULL_IDX);
        pv_wa = rd_next_r[IW-1:0];
        pv_wd = rd_prev_r;
        or_we = 1'b1;
        or_wa = mg_idx;
        or_wd = k_r + 5'd1;
      end
      C_PUSH_A: begin
        fr_we = 1'b1; or_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
        fr_wd = 1'b1;
      end
      C_PUSH_B: begin
        pv_we = (head_q != NULL_IDX);
        pv_wa = head_q[IW-1:0];
        pv_wd = h_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fr_we) free_mem[fr_wa]  <= fr_wd;
    if (or_we) order_mem[or_wa] <= or_wd;
    if (nx_we) next_mem[nx_wa]  <= nx_wd;
    if (pv_we) prev_mem[pv_wa]  <= pv_wd;
    rd_free_r  <= free_mem[rd_addr];
    rd_order_r <= order_mem[rd_addr];
    rd_next_r  <= next_mem[rd_addr];
    rd_prev_r  <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NORD; i++) begin
        heads_r[i] <= (i == NORD - 1) ? '0 : NULL_IDX;
      end
      clr_r   <= '0;
      base_r  <= '0;
      floor_r <= MERGE_FLOOR_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REGION_BASE: base_r  <= cfg_wdata;
          CFG_MERGE_FLOOR: floor_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      case (cmd)
        C_CLR:     clr_r <= clr_r + NW'(1);
        C_POP_WR:  heads_r[hsel] <= rd_next_r;
        C_SPLIT_B: heads_r[hsel] <= {1'b0, up_r};
        C_MEVAL:   if (bud_is_head) heads_r[hsel] <= rd_next_r;
        C_PUSH_B:  heads_r[hsel] <= {1'b0, h_r};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        k_r    <= MIN5;
        size_r <= SIZE_W'(req_bytes) + SIZE_W'(HEADER_BYTES);
        off_r  <= freed_addr - base_r - 32'(HEADER_BYTES);
      end
      C_STEP:   k_r <= k_r + 5'd1;
      C_POP_RD: h_r <= head_q[IW-1:0];
      C_SPLIT_A: begin
        k_r  <= k_r - 5'd1;
        up_r <= split_up;
        oh_r <= head_q;
      end
      C_AFIN: begin
        res_addr_r <= base_r + (32'(h_r) << MIN_ORDER) + 32'(HEADER_BYTES);
        res_ok_r   <= 1'b1;
      end
      C_FRD:  h_r <= off_r[MIN_ORDER +: IW];
      C_FCHK: k_r <= rd_order_r;
      C_MRD:  bud_r <= bud_idx;
      C_MEVAL: begin
        h_r <= mg_idx;
        k_r <= k_r + 5'd1;
      end
      C_PUSH_B: begin
        res_addr_r <= '0;
        res_ok_r   <= 1'b1;
      end
      C_FAIL: begin
        res_addr_r <= '0;
        res_ok_r   <= 1'b0;
      end
      C_EMIT: begin
        out_addr_r <= res_addr_r;
        out_ok_r   <= res_ok_r;
      end
      default: ;
    endcase
  end

  assign granted_addr = out_addr_r;
  assign grant_ok     = out_ok_r;

endmodule
`default_nettype wire

FILE: rtl/core/bba_ctrl.sv
// Controller: sequencer for clear, allocate and free, plus result valid.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  input  wire logic in_valid,
  input  wire logic in_op,
  input  wire logic out_ready,
  output cmd_t      cmd,
  output logic      in_ready,
  output logic      out_valid
);

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:     if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = (in_op == OP_FREE) ? S_FRD : S_SRCH;
      S_SRCH: begin
        if (sts.fit && sts.head_nn) state_nxt = S_POP_RD;
        else if (sts.k_max)         state_nxt = S_FAIL;
      end
      S_POP_RD:  state_nxt = S_POP_WR;
      S_POP_WR:  state_nxt = S_SPLIT_A;
      S_SPLIT_A: state_nxt = sts.can_split ? S_SPLIT_B : S_AFIN;
      S_SPLIT_B: state_nxt = S_SPLIT_A;
      S_AFIN:    state_nxt = S_POST;
      S_FRD:     state_nxt = sts.addr_bad ? S_FAIL : S_FCHK;
      S_FCHK: begin
        if (sts.chk_bad)       state_nxt = S_FAIL;
        else if (sts.merge_en) state_nxt = S_MRD;
        else                   state_nxt = S_PUSH_A;
      end
      S_MRD:     state_nxt = sts.k_lt_max ? S_MEVAL : S_PUSH_A;
      S_MEVAL:   state_nxt = sts.bud_match ? S_MRD : S_PUSH_A;
      S_PUSH_A:  state_nxt = S_PUSH_B;
      S_PUSH_B:  state_nxt = S_POST;
      S_FAIL:    state_nxt = S_POST;
      S_POST:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = C_NOP;
    in_ready = 1'b0;
    case (state_r)
      S_CLR: cmd = C_CLR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = C_LOAD;
      end
      S_SRCH:    if (!(sts.fit && sts.head_nn) && !sts.k_max) cmd = C_STEP;
      S_POP_RD:  cmd = C_POP_RD;
      S_POP_WR:  cmd = C_POP_WR;
      S_SPLIT_A: cmd = sts.can_split ? C_SPLIT_A : C_NOP;
      S_SPLIT_B: cmd = C_SPLIT_B;
      S_AFIN:    cmd = C_AFIN;
      S_FRD:     cmd = sts.addr_bad ? C_NOP : C_FRD;
      S_FCHK:    cmd = sts.chk_bad ? C_NOP : C_FCHK;
      S_MRD:     cmd = sts.k_lt_max ? C_MRD : C_NOP;
      S_MEVAL:   cmd = sts.bud_match ? C_MEVAL : C_NOP;
      S_PUSH_A:  cmd = C_PUSH_A;
      S_PUSH_B:  cmd = C_PUSH_B;
      S_FAIL:    cmd = C_FAIL;
      S_POST:    if (!out_valid_r || out_ready) cmd = C_EMIT;
      default:   cmd = C_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd == C_EMIT)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/core/buddy_block_allocator_unit.sv
// Top level: buddy allocator, controller plus datapath.
// Usage notes:
//  in_if  : requests. operation 0 allocates request_bytes (header excluded),
//           operation 1 frees freed_address. Accepted when valid && ready.
//  out_if : one result per request: granted_address and ok.
//  cfg_*  : write port; index 0 region_base, index 1 merge_floor. Write
//           only while no request is in flight.
//  Flow  : one request at a time, from acceptance to out_if.valid.
//           Allocate searches order by order for a free block that fits,
//           then splits it down; free checks the address and block,
//           then merges level by level. The next request can be taken
//           in the cycle after the result is posted. Single-port tables
//           and the order-by-order walk set the pace of each request.
//  Reset : synchronous, rst_n low. Afterward a clearing pass writes every
//          block table entry, 2^(MAX_ORDER-MIN_ORDER) of them (2048 by
//          default), with in_if.ready low; config writes still land.
//  Stall : a finished result sits in the output register; the next
//          request is accepted meanwhile, and its result waits until the
//          previous one is taken.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAX_ORDER    = MAX_ORDER_DEF,
  parameter int MIN_ORDER    = MIN_ORDER_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bba_in_if.sink           in_if,
  bba_out_if.source        out_if,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .in_valid  (in_if.valid),
    .in_op     (in_if.operation),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  bba_datapath #(
    .MAX_ORDER    (MAX_ORDER),
    .MIN_ORDER    (MIN_ORDER),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .req_bytes    (in_if.request_bytes),
    .freed_addr   (in_if.freed_address),
    .granted_addr (out_if.granted_address),
    .grant_ok     (out_if.ok)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

`ifndef SYNTH
  // one request in flight: ready drops right after acceptance
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("request accepted while another is in flight");

  // a failed result never carries an address
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ok |-> out_if.granted_address == 32'd0)
    else $error("failed result with nonzero address");

  // the controller only loads a request while ready is shown
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == C_LOAD |-> in_if.ready && in_if.valid)
    else $error("request loaded without handshake");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/buddy_block_allocator_unit_test.sv
// Testbench for the buddy allocator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module buddy_block_allocator_unit_test;
  import bba_pkg::*;

  localparam int NBLK = 2048;   // blocks of the minimum order
  localparam int NORD = 12;     // orders 5..16
  localparam int HDR = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic        op;
    logic [16:0] req_bytes;
    logic [31:0] addr;
  } request_t;

  typedef struct {
    logic [31:0] granted;
    logic        ok;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  bba_in_if in_ch();
  bba_out_if out_ch();

  buddy_block_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow allocator state, same widths as the block's tables.
  logic [31:0] shadow_base;
  logic [4:0]  shadow_floor;
  logic [11:0] free_head [NORD];
  logic        blk_free [NBLK];
  logic [4:0]  blk_order [NBLK];
  logic [10:0] blk_prev [NBLK];
  logic [11:0] blk_next [NBLK];

  request_t    pending_reqs[$];
  grant_t      expected_grants[$];
  int unsigned live_offsets[$];   // offsets of blocks currently handed out

  int  errors = 0;
  int  idle_mode = 0;             // 0 none, 1 sender, 2 receiver, 3 both
  int  quiet_cycles = 0;
  logic took_req = 1'b0;

  function automatic void list_push(int unsigned idx, int unsigned k);
    logic [11:0] h;
    h = free_head[k - 5];
    blk_next[idx] = h;
    blk_prev[idx] = '0;
    if (h < NBLK) blk_prev[h] = idx[10:0];
    free_head[k - 5] = idx[11:0];
  endfunction

  function automatic void list_unlink(int unsigned idx, int unsigned k);
    logic [11:0] nx;
    logic [10:0] pv;
    nx = blk_next[idx];
    pv = blk_prev[idx];
    if (free_head[k - 5] == idx) free_head[k - 5] = nx;
    else blk_next[pv] = nx;
    if (nx < NBLK) blk_prev[nx] = pv;
  endfunction

  function automatic grant_t alloc_predict(logic [16:0] req);
    grant_t g;
    int unsigned sz, k, h, up;
    g.granted = '0;
    g.ok = 1'b0;
    sz = req + HDR;
    for (k = 5; k <= 16; k++)
      if ((32'd1 << k) >= sz && free_head[k - 5] < NBLK) break;
    if (k > 16) return g;
    h = free_head[k - 5];
    free_head[k - 5] = blk_next[h];
    while (k > 5 && (32'd1 << (k - 1)) >= sz) begin
      k--;
      up = h + (1 << (k - 5));
      blk_free[up] = 1'b1;
      blk_order[up] = k[4:0];
      list_push(up, k);
    end
    blk_free[h] = 1'b0;
    blk_order[h] = k[4:0];
    g.granted = shadow_base + (h << 5) + HDR;
    g.ok = 1'b1;
    live_offsets.push_back(h << 5);
    return g;
  endfunction

  function automatic grant_t free_predict(logic [31:0] addr);
    grant_t g;
    int unsigned off, orig, idx, k, bud;
    int q[$];
    g.granted = '0;
    g.ok = 1'b0;
    off = addr - shadow_base - HDR;
    orig = off;
    if (off >= 65536 || off[4:0] != 0) return g;
    idx = off >> 5;
    k = blk_order[idx];
    if (k < 5 || k > 16 || (off & ((1 << k) - 1)) != 0 || blk_free[idx]) return g;
    if (k < 16 && k > shadow_floor) begin
      while (k < 16) begin
        bud = (off ^ (1 << k)) >> 5;
        if (!blk_free[bud] || blk_order[bud] != k) break;
        list_unlink(bud, k);
        if ((off & (1 << k)) != 0) begin
          off ^= (1 << k);
          idx = bud;
        end
        k++;
        blk_order[idx] = k[4:0];
      end
    end
    blk_free[idx] = 1'b1;
    blk_order[idx] = k[4:0];
    list_push(idx, k);
    g.ok = 1'b1;
    q = live_offsets.find_first_index(x) with (x == orig);
    if (q.size() > 0) live_offsets.delete(q[0]);
    return g;
  endfunction

  initial begin
    shadow_base = '0;
    shadow_floor = MERGE_FLOOR_RST;
    for (int i = 0; i < NBLK; i++) begin
      blk_free[i] = 1'b0;
      blk_order[i] = '0;
      blk_prev[i] = '0;
      blk_next[i] = '0;
    end
    for (int i = 0; i < NORD; i++) free_head[i] = 12'(NBLK);
    free_head[NORD - 1] = '0;
    blk_free[0] = 1'b1;
    blk_order[0] = 5'd16;
    blk_next[0] = 12'(NBLK);
  end

  // Sample side: check results, predict accepted requests, track config writes.
  always @(posedge clk) begin
    grant_t got, want, g;
    request_t r;
    logic took;
    took = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.granted = out_ch.granted_address;
        got.ok = out_ch.ok;
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result addr=%h ok=%b", $time, got.granted, got.ok);
          errors++;
        end else begin
          want = expected_grants.pop_front();
          if (got.granted !== want.granted) begin
            $display("%0t: granted_address expected %h actual %h",
                     $time, want.granted, got.granted);
            errors++;
          end
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        r = pending_reqs.pop_front();
        g = (r.op == OP_ALLOC) ? alloc_predict(r.req_bytes) : free_predict(r.addr);
        expected_grants.push_back(g);
        took = 1'b1;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
    if (cfg_we) begin
      if (cfg_index == CFG_REGION_BASE) shadow_base = cfg_wdata;
      else shadow_floor = cfg_wdata[4:0];
    end
    took_req <= took;
  end

  // Drive side: requests and result backpressure, changed on the falling edge.
  always @(negedge clk) begin
    bit sender_idle, recv_stall;
    sender_idle = (idle_mode == 1 || idle_mode == 3) &&
                  ($urandom_range(99) < ((idle_mode == 1) ? 61 : 30));
    recv_stall = (idle_mode == 2 || idle_mode == 3) &&
                 ($urandom_range(99) < ((idle_mode == 2) ? 61 : 30));
    out_ch.ready <= rst_n && !recv_stall;
    if (rst_n && (!in_ch.valid || took_req)) begin
      if (pending_reqs.size() > 0 && !sender_idle) begin
        in_ch.valid <= 1'b1;
        in_ch.operation <= pending_reqs[0].op;
        in_ch.request_bytes <= pending_reqs[0].req_bytes;
        in_ch.freed_address <= pending_reqs[0].addr;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic queue_req(logic op, logic [16:0] req, logic [31:0] addr);
    request_t r;
    r.op = op;
    r.req_bytes = req;
    r.addr = addr;
    pending_reqs.push_back(r);
  endtask

  task automatic drain_and_settle();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One burst of traffic built from the blocks currently held; waits for it to finish.
  task automatic random_burst(int n);
    int unsigned held[$];
    int unsigned pick, off;
    logic [31:0] junk;
    held = live_offsets;
    for (int i = 0; i < n; i++) begin
      junk = $urandom();
      if ($urandom_range(99) < 6) begin
        // bad free: out of range or misaligned, never an unwritten entry
        off = junk - shadow_base - HDR;
        if (off < 65536 && off[4:0] == 0) junk[0] = ~junk[0];
        queue_req(OP_FREE, 17'($urandom()), junk);
      end else if (held.size() == 0 || (held.size() < 24 && $urandom_range(1))) begin
        case ($urandom_range(9))
          0: queue_req(OP_ALLOC, 17'($urandom_range(65536)), junk);
          1: queue_req(OP_ALLOC, 17'($urandom()), junk);
          2: queue_req(OP_ALLOC, '0, junk);
          default: queue_req(OP_ALLOC, 17'($urandom_range(1500)), junk);
        endcase
      end else begin
        pick = $urandom_range(held.size() - 1);
        queue_req(OP_FREE, 17'($urandom()), shadow_base + held[pick] + HDR);
        // occasionally keep it around so a double free can follow
        if ($urandom_range(19) != 0) held.delete(pick);
      end
    end
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_ch.valid)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] bases [8];
    logic [4:0]  floors [8];
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.freed_address = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    bases = '{32'h0, 32'hFFFF_FFE0, 32'h1234_5600, 32'hFFFF_FFFF,
              32'h8000_0000, $urandom(), 32'h0000_0100, $urandom()};
    floors = '{5'd10, 5'd0, 5'd16, 5'd5, 5'd15, 5'($urandom_range(16)), 5'd6, 5'd0};

    // Directed: whole region, failures, bad and double frees, smallest blocks.
    write_reg(CFG_REGION_BASE, 32'h0);
    write_reg(CFG_MERGE_FLOOR, 32'd0);
    queue_req(OP_ALLOC, 17'd65504, '0);      // takes the whole region at 32
    queue_req(OP_ALLOC, 17'd0, '0);          // nothing left
    queue_req(OP_ALLOC, 17'd65536, '0);      // can never fit
    queue_req(OP_FREE, '0, 32'd32);
    queue_req(OP_FREE, '0, 32'd32);          // double free
    queue_req(OP_FREE, '0, 32'd33);          // misaligned
    queue_req(OP_FREE, '0, 32'd0);           // wraps below the region
    queue_req(OP_FREE, '1, 32'hFFFF_FFFF);   // far out of range
    queue_req(OP_ALLOC, 17'd0, '0);
    queue_req(OP_ALLOC, 17'd0, '0);
    queue_req(OP_ALLOC, 17'd1, '0);
    queue_req(OP_ALLOC, 17'd32736, '0);
    queue_req(OP_FREE, '0, 32'd96);          // the order-6 block, buddy still held
    queue_req(OP_FREE, '0, 32'd64);
    queue_req(OP_FREE, '0, 32'd32);
    queue_req(OP_ALLOC, 17'h1FFFF, '0);      // largest value the field can hold; can never fit
    drain_and_settle();

    // Free every held block one at a time, waiting for each result before the next.
    while (live_offsets.size() > 0) begin
      queue_req(OP_FREE, '0, shadow_base + live_offsets[0] + HDR);
      while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_ch.valid)
        @(posedge clk);
    end

    for (int p = 0; p < 8; p++) begin
      drain_and_settle();
      write_reg(CFG_REGION_BASE, bases[p]);
      write_reg(CFG_MERGE_FLOOR, {27'd0, floors[p]});
      idle_mode = p % 4;
      for (int b = 0; b < 12; b++) begin
        random_burst($urandom_range(10, 30));
      end
      // a final short burst of eight requests for this phase
      random_burst(8);
    end

    drain_and_settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
